FILE: rtl/ssi_pkg.sv
// Package for the segment / sphere intersection pipeline.
// Holds the fixed field widths, pipeline constants and payload structs.
// Depends on nothing; imported by ssi_mul, ssi_sqrt, ssi_div and the top level.
`default_nettype none
package ssi_pkg;

  // Coordinate width in bits (signed fixed point, fraction position irrelevant).
  localparam int COORD_BITS = 32;
  // Fraction bits produced for the segment parameter t.
  localparam int TFRAC      = 32;
  // Register stages of one ssi_mul instance.
  localparam int MUL_LAT    = 4;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] start_z;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic signed [COORD_BITS-1:0] end_z;
    logic signed [COORD_BITS-1:0] centre_x;
    logic signed [COORD_BITS-1:0] centre_y;
    logic signed [COORD_BITS-1:0] centre_z;
    logic        [COORD_BITS-2:0] radius;
  } ssi_in_t;

  typedef struct packed {
    logic                         hit;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
  } ssi_out_t;

endpackage
`default_nettype wire

FILE: rtl/ssi_delay.sv
// Enabled shift-register delay line for data that rides alongside the pipeline.
// Uses no package items; instantiated by the top level.
`default_nettype none
module ssi_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [WIDTH-1:0] d_i,
  output logic      [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] pipe_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        pipe_q[i] <= pipe_q[i-1];
      end
    end
  end

  assign q_o = pipe_q[DEPTH-1];

endmodule
`default_nettype wire

FILE: rtl/ssi_mul.sv
// Pipelined signed multiplier: magnitude, four half-width partial products,
// sum, then sign, each registered in turn.
`default_nettype none
module ssi_mul #(
  parameter int AW = 33
) (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic signed [AW-1:0] a_i,
  input  wire logic signed [AW-1:0] b_i,
  output logic signed [2*AW-1:0]    p_o
);
  import ssi_pkg::*;

  localparam int LW = (AW + 1) / 2;
  localparam int HW = AW - LW;
  localparam int PW = 2 * AW;

  logic [AW-1:0]      mag_a_q, mag_b_q;
  logic               neg1_q, neg2_q, neg3_q;
  logic [2*LW-1:0]    ll_q;
  logic [LW+HW-1:0]   lh_q, hl_q;
  logic [2*HW-1:0]    hh_q;
  logic [PW-1:0]      sum_q;
  logic signed [PW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_a_q <= a_i[AW-1] ? AW'(-a_i) : AW'(a_i);
      mag_b_q <= b_i[AW-1] ? AW'(-b_i) : AW'(b_i);
      neg1_q  <= a_i[AW-1] ^ b_i[AW-1];

      ll_q   <= mag_a_q[LW-1:0] * mag_b_q[LW-1:0];
      lh_q   <= mag_a_q[LW-1:0] * mag_b_q[AW-1:LW];
      hl_q   <= mag_a_q[AW-1:LW] * mag_b_q[LW-1:0];
      hh_q   <= mag_a_q[AW-1:LW] * mag_b_q[AW-1:LW];
      neg2_q <= neg1_q;

      sum_q  <= (PW'(hh_q) << (2 * LW)) + ((PW'(lh_q) + PW'(hl_q)) << LW) + PW'(ll_q);
      neg3_q <= neg2_q;

      p_q    <= neg3_q ? -$signed(sum_q) : $signed(sum_q);
    end
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

FILE: rtl/ssi_sqrt.sv
// Fully pipelined floor square root, two radicand bits per stage.
// Uses no package items beyond the import.
`default_nettype none
module ssi_sqrt #(
  parameter int DW = 134
) (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [DW-1:0]     d_i,
  output logic      [DW/2-1:0]   s_o
);
  import ssi_pkg::*;

  localparam int HW = DW / 2;
  localparam int RW = HW + 3;

  logic [RW-1:0] rem_q  [HW];
  logic [HW-1:0] root_q [HW];
  logic [DW-1:0] rest_q [HW];

  for (genvar gi = 0; gi < HW; gi++) begin : g_stage
    logic [RW-1:0] rem_c, shifted, trial;
    logic [HW-1:0] root_c;
    logic [DW-1:0] rest_c;
    logic          ge;

    if (gi == 0) begin : g_first
      assign rem_c  = '0;
      assign root_c = '0;
      assign rest_c = d_i;
    end else begin : g_next
      assign rem_c  = rem_q[gi-1];
      assign root_c = root_q[gi-1];
      assign rest_c = rest_q[gi-1];
    end

    assign shifted = {rem_c[RW-3:0], rest_c[DW-1:DW-2]};
    assign trial   = RW'({root_c, 2'b01});
    assign ge      = (shifted >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[gi]  <= ge ? (shifted - trial) : shifted;
        root_q[gi] <= {root_c[HW-2:0], ge};
        rest_q[gi] <= rest_c << 2;
      end
    end
  end

  assign s_o = root_q[HW-1];

endmodule
`default_nettype wire

FILE: rtl/ssi_div.sv
// Fully pipelined restoring divider giving TFRAC fraction bits of n / a
// for 0 <= n < a; TFRAC comes from ssi_pkg.
`default_nettype none
module ssi_div #(
  parameter int NW = 66
) (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [NW-1:0]     n_i,
  input  wire logic [NW-1:0]     a_i,
  output logic [ssi_pkg::TFRAC-1:0] q_o
);
  import ssi_pkg::*;

  logic [NW-1:0]    rem_q [TFRAC];
  logic [NW-1:0]    den_q [TFRAC];
  logic [TFRAC-1:0] quo_q [TFRAC];

  for (genvar gi = 0; gi < TFRAC; gi++) begin : g_stage
    logic [NW-1:0]    rem_c, den_c;
    logic [TFRAC-1:0] quo_c;
    logic [NW:0]      sh, diff;
    logic             ge;

    if (gi == 0) begin : g_first
      assign rem_c = n_i;
      assign den_c = a_i;
      assign quo_c = '0;
    end else begin : g_next
      assign rem_c = rem_q[gi-1];
      assign den_c = den_q[gi-1];
      assign quo_c = quo_q[gi-1];
    end

    assign sh   = {rem_c, 1'b0};
    assign ge   = (sh >= {1'b0, den_c});
    assign diff = sh - {1'b0, den_c};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[gi] <= ge ? diff[NW-1:0] : sh[NW-1:0];
        den_q[gi] <= den_c;
        quo_q[gi] <= {quo_c[TFRAC-2:0], ge};
      end
    end
  end

  assign q_o = quo_q[TFRAC-1];

endmodule
`default_nettype wire

FILE: rtl/segment_sphere_intersection.sv
// Top level of the segment / sphere intersection pipeline.
// Depends on ssi_pkg, ssi_delay, ssi_mul, ssi_sqrt and ssi_div.
//
// Usage: one transaction on the input channel carries a segment (start and
// end points) and a sphere (centre and radius) as an ssi_in_t. One
// transaction on the output channel returns an ssi_out_t: hit is set when
// the nearer root t of the line/sphere quadratic lies strictly between 0
// and 1, and then the point start + t*(end - start) is given; otherwise the
// point fields are zero. Each input transaction yields exactly one result.
// Throughput is one transaction per cycle while no waiting result is stalled.
// The square root of the discriminant works two bits per stage and the
// divider that forms t one bit per stage.
// Reset clears the valid bits of every stage, so the pipeline comes up empty.
// When the receiver stalls a waiting result, the whole pipeline freezes and
// in_stall_o rises in the same cycle; nothing is lost or repeated, and the
// pipeline moves on as soon as the stall drops.
`default_nettype none
module segment_sphere_intersection (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire ssi_pkg::ssi_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output ssi_pkg::ssi_out_t     out_data_o
);
  import ssi_pkg::*;

  localparam int W     = COORD_BITS;
  localparam int AW1   = W + 1;           // differences
  localparam int AW2   = 2 * W + 3;       // a, h, c (signed)
  localparam int DW    = 2 * AW2;         // discriminant
  localparam int SQH   = DW / 2;          // square root width and stages
  localparam int NSW   = 2 * W + 5;       // -h - s (signed)
  localparam int NW    = 2 * W + 2;       // a and N as unsigned
  localparam int PW    = (TFRAC > W) ? TFRAC + 1 : W + 1;
  localparam int LAT   = 5 + 3 * MUL_LAT + SQH + TFRAC;
  localparam int ST_DLY  = LAT - 2;
  localparam int DV_DLY  = 3 + 2 * MUL_LAT + SQH + TFRAC;
  localparam int HA_DLY  = 1 + MUL_LAT + SQH;
  localparam int OK_DLY  = TFRAC + MUL_LAT;

  // The whole pipeline advances together unless a finished result is held.
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  logic [LAT-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end
  assign out_valid_o = vld_q[LAT-1];

  // Stage A: register start points and form the differences d and e.
  logic signed [W-1:0]   st_in [3];
  logic signed [W-1:0]   en_in [3];
  logic signed [W-1:0]   ce_in [3];
  logic signed [W-1:0]   st_q  [3];
  logic signed [AW1-1:0] dv_q  [3];
  logic signed [AW1-1:0] ev_q  [3];
  logic signed [AW1-1:0] r_q;

  always_comb begin
    st_in[0] = in_data_i.start_x;  st_in[1] = in_data_i.start_y;
    st_in[2] = in_data_i.start_z;
    en_in[0] = in_data_i.end_x;    en_in[1] = in_data_i.end_y;
    en_in[2] = in_data_i.end_z;
    ce_in[0] = in_data_i.centre_x; ce_in[1] = in_data_i.centre_y;
    ce_in[2] = in_data_i.centre_z;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        st_q[k] <= st_in[k];
        dv_q[k] <= AW1'(en_in[k]) - AW1'(st_in[k]);
        ev_q[k] <= AW1'(st_in[k]) - AW1'(ce_in[k]);
      end
      r_q <= $signed({2'b00, in_data_i.radius});
    end
  end

  // First multiplier bank: the dot products d.d, d.e, e.e and radius squared.
  logic signed [2*AW1-1:0] dd_p [3];
  logic signed [2*AW1-1:0] de_p [3];
  logic signed [2*AW1-1:0] ee_p [3];
  logic signed [2*AW1-1:0] rr_p;

  for (genvar k = 0; k < 3; k++) begin : g_dot
    ssi_mul #(.AW(AW1)) u_dd (.clk_i, .en_i(en), .a_i(dv_q[k]), .b_i(dv_q[k]), .p_o(dd_p[k]));
    ssi_mul #(.AW(AW1)) u_de (.clk_i, .en_i(en), .a_i(dv_q[k]), .b_i(ev_q[k]), .p_o(de_p[k]));
    ssi_mul #(.AW(AW1)) u_ee (.clk_i, .en_i(en), .a_i(ev_q[k]), .b_i(ev_q[k]), .p_o(ee_p[k]));
  end
  ssi_mul #(.AW(AW1)) u_rr (.clk_i, .en_i(en), .a_i(r_q), .b_i(r_q), .p_o(rr_p));

  // Sum stage: the quadratic coefficients a, h (half of b) and c.
  logic signed [AW2-1:0] a_q, h_q, c_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q <= AW2'(dd_p[0]) + AW2'(dd_p[1]) + AW2'(dd_p[2]);
      h_q <= AW2'(de_p[0]) + AW2'(de_p[1]) + AW2'(de_p[2]);
      c_q <= AW2'(ee_p[0]) + AW2'(ee_p[1]) + AW2'(ee_p[2]) - AW2'(rr_p);
    end
  end

  // Second multiplier bank for the quarter discriminant h*h - a*c.
  logic signed [DW-1:0] hh_p, ac_p;
  ssi_mul #(.AW(AW2)) u_hh (.clk_i, .en_i(en), .a_i(h_q), .b_i(h_q), .p_o(hh_p));
  ssi_mul #(.AW(AW2)) u_ac (.clk_i, .en_i(en), .a_i(a_q), .b_i(c_q), .p_o(ac_p));

  logic [DW-1:0] dsc_q;
  logic          dneg_q;
  logic signed [DW-1:0] dsc_d;
  assign dsc_d = hh_p - ac_p;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dneg_q <= dsc_d[DW-1];
      dsc_q  <= dsc_d[DW-1] ? '0 : dsc_d;
    end
  end

  logic [SQH-1:0] sq_s;
  ssi_sqrt #(.DW(DW)) u_sqrt (.clk_i, .en_i(en), .d_i(dsc_q), .s_o(sq_s));

  logic [0:0]     dneg_dly;
  logic [AW2-1:0] h_dly, a_dly;
  ssi_delay #(.WIDTH(1), .DEPTH(SQH)) u_dneg_dly (
    .clk_i, .en_i(en), .d_i(dneg_q), .q_o(dneg_dly));
  ssi_delay #(.WIDTH(AW2), .DEPTH(HA_DLY)) u_h_dly (
    .clk_i, .en_i(en), .d_i(h_q), .q_o(h_dly));
  ssi_delay #(.WIDTH(AW2), .DEPTH(HA_DLY)) u_a_dly (
    .clk_i, .en_i(en), .d_i(a_q), .q_o(a_dly));

  // Root stage: N = -h - sqrt(D); a hit needs a != 0, D >= 0 and 0 < N < a.
  logic signed [NSW-1:0] n_d, a_ext;
  logic                  ok_d, ok_q;
  logic [NW-1:0]         n_q, an_q;

  assign n_d   = -NSW'($signed(h_dly)) - $signed(NSW'(sq_s));
  assign a_ext = NSW'($signed(a_dly));
  assign ok_d  = !dneg_dly[0] && (a_ext != '0) && (n_d > 0) && (n_d < a_ext);

  always_ff @(posedge clk_i) begin
    if (en) begin
      ok_q <= ok_d;
      n_q  <= ok_d ? n_d[NW-1:0] : '0;
      an_q <= ok_d ? a_dly[NW-1:0] : NW'(1);
    end
  end

  logic [TFRAC-1:0] t_q;
  ssi_div #(.NW(NW)) u_div (.clk_i, .en_i(en), .n_i(n_q), .a_i(an_q), .q_o(t_q));

  // Point stage: start + floor(t * d), with t as an unsigned fraction.
  logic [3*AW1-1:0] dv_dly;
  logic [3*W-1:0]   st_dly;
  logic [0:0]       ok_dly;
  ssi_delay #(.WIDTH(3*AW1), .DEPTH(DV_DLY)) u_dv_dly (
    .clk_i, .en_i(en), .d_i({dv_q[0], dv_q[1], dv_q[2]}), .q_o(dv_dly));
  ssi_delay #(.WIDTH(3*W), .DEPTH(ST_DLY)) u_st_dly (
    .clk_i, .en_i(en), .d_i({st_q[0], st_q[1], st_q[2]}), .q_o(st_dly));
  ssi_delay #(.WIDTH(1), .DEPTH(OK_DLY)) u_ok_dly (
    .clk_i, .en_i(en), .d_i(ok_q), .q_o(ok_dly));

  logic signed [PW-1:0]   t_ext;
  logic signed [PW-1:0]   d_ext [3];
  logic signed [2*PW-1:0] td_p  [3];
  logic signed [W-1:0]    pt    [3];

  assign t_ext = $signed(PW'(t_q));
  for (genvar k = 0; k < 3; k++) begin : g_point
    assign d_ext[k] = PW'($signed(dv_dly[(2-k)*AW1 +: AW1]));
    ssi_mul #(.AW(PW)) u_td (.clk_i, .en_i(en), .a_i(t_ext), .b_i(d_ext[k]), .p_o(td_p[k]));
    assign pt[k] = $signed(st_dly[(2-k)*W +: W]) + $signed(td_p[k][TFRAC +: W]);
  end

  ssi_out_t out_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.hit     <= ok_dly[0];
      out_q.point_x <= ok_dly[0] ? pt[0] : '0;
      out_q.point_y <= ok_dly[0] ? pt[1] : '0;
      out_q.point_z <= ok_dly[0] ? pt[2] : '0;
    end
  end
  assign out_data_o = out_q;

endmodule
`default_nettype wire
